/* sv/spa_pkg.sv */
package spa_pkg;

  localparam int unsigned OpW     = 1;
  localparam int unsigned VoxelW  = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned StartW  = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned AccW    = 32;
  localparam int unsigned DetCntW = 8;
  localparam int unsigned PlnCntW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  // Product widths of the contribution chain.
  localparam int unsigned GainColW = 32;
  localparam int unsigned PartialW = 48;
  localparam int unsigned ProductW = 64;

  // Number of line weight fields an item carries.
  localparam int unsigned WeightFields = 4;

  // Quotient bits the divider produces, one per cycle.
  localparam int unsigned DivSteps = IndexW;
  localparam int unsigned DivCntW  = 4;

  localparam logic [CfgIdxW-1:0] CfgDetectorCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneCount    = 2'd1;

  localparam logic OpAccumulate = 1'b0;
  localparam logic OpRead       = 1'b1;

  localparam logic [DetCntW-1:0] DetCntReset = 8'd128;
  localparam logic [PlnCntW-1:0] PlnCntReset = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_BASE,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic clear;
    logic read;
    logic commit;
  } lane_cmd_t;

endpackage

/* sv/spa_divider.sv */
module spa_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [spa_pkg::IndexW-1:0]       dividend_i,
  input  logic [spa_pkg::DetCntW-1:0]      divisor_i,
  output logic                             done_o,
  output logic [spa_pkg::IndexW-1:0]       quotient_o,
  output logic [spa_pkg::DetCntW-1:0]      remainder_o
);

  logic                        busy_q, busy_d;
  logic [spa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [spa_pkg::IndexW-1:0]  quo_q, quo_d;
  logic [spa_pkg::DetCntW-1:0] rem_q, rem_d;
  logic [spa_pkg::DetCntW:0]   trial;
  logic                        fits;

  // Restoring division: the dividend shifts out of the quotient register as
  // quotient bits shift in.
  always_comb begin
    trial  = {rem_q, quo_q[spa_pkg::IndexW-1]};
    fits   = trial >= {1'b0, divisor_i};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[spa_pkg::IndexW-2:0], fits};
      rem_d = fits ? spa_pkg::DetCntW'(trial - {1'b0, divisor_i})
                   : spa_pkg::DetCntW'(trial);
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == spa_pkg::DivCntW'(spa_pkg::DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* sv/spa_lane.sv */
module spa_lane #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned RowW  = 14
) (
  input  logic                               clk_i,
  input  spa_pkg::lane_cmd_t                 cmd_i,
  input  logic [RowW-1:0]                    row_i,
  input  logic                               active_i,
  input  logic [spa_pkg::PartialW-1:0]       partial_i,
  input  logic [spa_pkg::WeightW-1:0]        weight_i,
  input  logic                               negative_i,
  output logic [spa_pkg::AccW-1:0]           rdata_o
);

  logic [spa_pkg::AccW-1:0]     mem [Depth];
  logic [spa_pkg::AccW-1:0]     rdata_q;
  logic [spa_pkg::ProductW-1:0] prod_q;
  logic [spa_pkg::ProductW-1:0] rounded_full;
  logic [spa_pkg::AccW-1:0]     rounded;
  logic signed [spa_pkg::AccW+1:0] contrib;
  logic signed [spa_pkg::AccW+1:0] sum;
  logic [spa_pkg::AccW-1:0]     sat;

  // The partial product is steady while an item is at work, so this register
  // settles long before the accumulator is read.
  always_ff @(posedge clk_i) begin
    prod_q <= partial_i * spa_pkg::ProductW'(weight_i);
  end

  always_comb begin
    rounded_full = prod_q + (spa_pkg::ProductW'(1) << 31);
    rounded      = rounded_full[spa_pkg::ProductW-1:spa_pkg::AccW];
    contrib      = negative_i ? -$signed({2'b00, rounded}) : $signed({2'b00, rounded});
    sum          = $signed({{2{rdata_q[spa_pkg::AccW-1]}}, rdata_q}) + contrib;
    if (sum > $signed({3'b000, {(spa_pkg::AccW-1){1'b1}}})) begin
      sat = {1'b0, {(spa_pkg::AccW-1){1'b1}}};
    end else if (sum < $signed({3'b111, {(spa_pkg::AccW-1){1'b0}}})) begin
      sat = {1'b1, {(spa_pkg::AccW-1){1'b0}}};
    end else begin
      sat = sum[spa_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[row_i] <= '0;
    end else if (cmd_i.commit && active_i) begin
      mem[row_i] <= sat;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[row_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/spa_merge.sv */
module spa_merge #(
  parameter int unsigned Banks = 4
) (
  input  logic [spa_pkg::AccW-1:0] rdata_i [Banks],
  input  logic [1:0]               bank_i,
  input  logic                     invalid_i,
  output logic [spa_pkg::AccW-1:0] value_o
);

  always_comb begin
    value_o = '0;
    for (int b = 0; b < Banks; b++) begin
      if (!invalid_i && bank_i == 2'(b)) begin
        value_o = rdata_i[b];
      end
    end
  end

endmodule

/* sv/sparse_projection_accumulator_unit.sv */
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o   operation_i .. line_weight_d_i
// out      output     out_valid_o / out_ready_i accumulator_value_o, address_invalid_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An item passes from transfer to the next ready through the bit-serial split of
// the 12-bit detector_index by detector_count, then address, read and write-back.
// After reset the banks are cleared one row per cycle, VIEWS*DETECTORS*
// ceil(PLANES/banks) rows (16384 by default); no input transfer is taken then.
// A finished read result waits in the output register; the next item is taken
// meanwhile, but a later read stalls in its write-back step until it drains.
module sparse_projection_accumulator_unit #(
  parameter int unsigned VIEWS     = 32,
  parameter int unsigned DETECTORS = 128,
  parameter int unsigned PLANES    = 16,
  parameter int unsigned LANES     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic signed [spa_pkg::VoxelW-1:0] voxel_value_i,
  input  logic [spa_pkg::WeightW-1:0]       column_weight_i,
  input  logic [spa_pkg::IndexW-1:0]        detector_index_i,
  input  logic [spa_pkg::WeightW-1:0]       view_gain_i,
  input  logic [spa_pkg::StartW-1:0]        line_start_i,
  input  logic [spa_pkg::CountW-1:0]        line_count_i,
  input  logic [spa_pkg::WeightW-1:0]       line_weight_a_i,
  input  logic [spa_pkg::WeightW-1:0]       line_weight_b_i,
  input  logic [spa_pkg::WeightW-1:0]       line_weight_c_i,
  input  logic [spa_pkg::WeightW-1:0]       line_weight_d_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [spa_pkg::AccW-1:0]   accumulator_value_o,
  output logic                              address_invalid_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spa_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [spa_pkg::CfgDatW-1:0]       cfg_data_i
);

  localparam int unsigned LanesEff  = (LANES < spa_pkg::WeightFields) ? LANES
                                                                       : spa_pkg::WeightFields;
  localparam int unsigned Banks     = (LanesEff <= 1) ? 1 : ((LanesEff <= 2) ? 2 : 4);
  localparam int unsigned Shift     = $clog2(Banks);
  localparam int unsigned PlaneRows = (PLANES + Banks - 1) / Banks;
  localparam int unsigned Depth     = VIEWS * DETECTORS * PlaneRows;
  localparam int unsigned RowW      = (Depth > 1) ? $clog2(Depth) : 1;

  spa_pkg::state_e state_q, state_d;

  logic [spa_pkg::DetCntW-1:0] det_cnt_q;
  logic [spa_pkg::PlnCntW-1:0] pln_cnt_q;
  logic [RowW-1:0]             clr_q, clr_d;

  logic                        op_q;
  logic [spa_pkg::VoxelW-1:0]  voxel_q;
  logic [spa_pkg::WeightW-1:0] column_q, gain_q;
  logic [spa_pkg::StartW-1:0]  start_q;
  logic [spa_pkg::CountW-1:0]  count_q;
  logic [spa_pkg::WeightW-1:0] weight_q [spa_pkg::WeightFields];

  logic [spa_pkg::GainColW-1:0] gaincol_q;
  logic [spa_pkg::PartialW-1:0] partial_q;
  logic                         negative;
  logic [spa_pkg::VoxelW-1:0]   mag;

  logic                        div_done;
  logic [spa_pkg::IndexW-1:0]  view;
  logic [spa_pkg::DetCntW-1:0] det;
  logic [spa_pkg::DetCntW-1:0] divisor;
  logic                        inside_q;
  logic [RowW-1:0]             base_q;

  logic                        out_valid_q;
  logic [spa_pkg::AccW-1:0]    acc_q;
  logic                        inv_q;
  logic                        rd_invalid;
  logic [spa_pkg::AccW-1:0]    merged;

  logic                        in_xfer;
  spa_pkg::lane_cmd_t          cmd;
  logic [spa_pkg::CountW-1:0]  lanes_used;
  logic [spa_pkg::PlnCntW-1:0] limit;
  logic [RowW-1:0]             row   [Banks];
  logic                        active [Banks];
  logic [spa_pkg::WeightW-1:0] lane_w [Banks];
  logic [spa_pkg::AccW-1:0]    rdata [Banks];

  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == spa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_cnt_q <= spa_pkg::DetCntReset;
      pln_cnt_q <= spa_pkg::PlnCntReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spa_pkg::CfgDetectorCount: det_cnt_q <= cfg_data_i;
        spa_pkg::CfgPlaneCount:    pln_cnt_q <= cfg_data_i[spa_pkg::PlnCntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= operation_i;
      voxel_q     <= voxel_value_i;
      column_q    <= column_weight_i;
      gain_q      <= view_gain_i;
      start_q     <= line_start_i;
      count_q     <= line_count_i;
      weight_q[0] <= line_weight_a_i;
      weight_q[1] <= line_weight_b_i;
      weight_q[2] <= line_weight_c_i;
      weight_q[3] <= line_weight_d_i;
    end
  end

  // The shared part of the product settles during the division.
  assign negative = voxel_q[spa_pkg::VoxelW-1];
  assign mag      = negative ? (~voxel_q + 1'b1) : voxel_q;

  always_ff @(posedge clk_i) begin
    gaincol_q <= gain_q * spa_pkg::GainColW'(column_q);
    partial_q <= gaincol_q * spa_pkg::PartialW'(mag);
  end

  assign divisor = (det_cnt_q == '0) ? spa_pkg::DetCntW'(1) : det_cnt_q;

  // The divider loads the index straight from the input port at the transfer.
  spa_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .dividend_i  (detector_index_i),
    .divisor_i   (divisor),
    .done_o      (div_done),
    .quotient_o  (view),
    .remainder_o (det)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == spa_pkg::ST_BASE) begin
      inside_q <= (32'(view) < VIEWS) && (32'(det) < DETECTORS);
      base_q   <= RowW'((32'(view) * 32'(DETECTORS) + 32'(det)) * 32'(PlaneRows));
    end
  end

  assign lanes_used = (32'(count_q) < LanesEff) ? count_q : spa_pkg::CountW'(LanesEff);
  assign limit      = (32'(pln_cnt_q) < PLANES) ? pln_cnt_q : spa_pkg::PlnCntW'(PLANES);

  // Bank b holds the planes congruent to b; it takes line weight q where
  // start + q lands in it.
  for (genvar b = 0; b < Banks; b++) begin : g_lane
    logic [1:0]                q;
    logic [spa_pkg::StartW:0]  plane;

    assign q         = 2'((2'(b) - 2'(start_q)) & 2'(Banks - 1));
    assign plane     = {1'b0, start_q} + (spa_pkg::StartW+1)'(q);
    assign row[b]    = (state_q == spa_pkg::ST_CLEAR) ? clr_q
                                                      : base_q + RowW'(plane >> Shift);
    assign lane_w[b] = weight_q[q];
    assign active[b] = (op_q == spa_pkg::OpAccumulate) && inside_q
                       && (3'(q) < lanes_used) && (6'(plane) < 6'(limit));

    spa_lane #(
      .Depth (Depth),
      .RowW  (RowW)
    ) u_lane (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .row_i      (row[b]),
      .active_i   (active[b]),
      .partial_i  (partial_q),
      .weight_i   (lane_w[b]),
      .negative_i (negative),
      .rdata_o    (rdata[b])
    );
  end

  assign rd_invalid = !inside_q || (32'(start_q) >= PLANES);

  spa_merge #(
    .Banks (Banks)
  ) u_merge (
    .rdata_i   (rdata),
    .bank_i    (2'(start_q) & 2'(Banks - 1)),
    .invalid_i (rd_invalid),
    .value_o   (merged)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd     = '0;
    unique case (state_q)
      spa_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        clr_d     = clr_q + 1'b1;
        if (clr_q == RowW'(Depth - 1)) begin
          state_d = spa_pkg::ST_IDLE;
        end
      end
      spa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = spa_pkg::ST_DIVIDE;
        end
      end
      spa_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = spa_pkg::ST_BASE;
        end
      end
      spa_pkg::ST_BASE: begin
        state_d = spa_pkg::ST_READ;
      end
      spa_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_d  = spa_pkg::ST_WRITE;
      end
      spa_pkg::ST_WRITE: begin
        if (op_q == spa_pkg::OpAccumulate) begin
          cmd.commit = 1'b1;
          state_d    = spa_pkg::ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          state_d = spa_pkg::ST_IDLE;
        end
      end
      default: state_d = spa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spa_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == spa_pkg::ST_WRITE && op_q == spa_pkg::OpRead
                 && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spa_pkg::ST_WRITE && op_q == spa_pkg::OpRead
        && (!out_valid_q || out_ready_i)) begin
      acc_q <= merged;
      inv_q <= rd_invalid;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accumulator_value_o = acc_q;
  assign address_invalid_o   = inv_q;

  // A new result only ever follows a read item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(op_q) == spa_pkg::OpRead)
    else $error("result without a read item");

  // The banks are written back only for accumulate items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> op_q == spa_pkg::OpAccumulate && $past(cmd.read))
    else $error("write-back without a preceding read");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == spa_pkg::ST_DIVIDE)
    else $error("divider finished out of step");

endmodule
